FILE: hw/rtl/bmhq_pkg.sv
// Shared types and constants of the bounded min-heap queue.
package bmhq_pkg;

  localparam int KEY_W     = 34;
  localparam int POINT_W   = 16;
  localparam int SLOT_W    = 9;
  localparam int COUNT_W   = 9;
  localparam int LIMIT_W   = 9;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

  typedef enum logic [1:0] {
    FUNC_PUSH  = 2'd0,
    FUNC_POP   = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_LOOK  = 2'd3
  } func_t;

  typedef struct packed {
    func_t               func;
    logic [KEY_W-1:0]    dist_key;
    logic [POINT_W-1:0]  point_id;
    logic [SLOT_W-1:0]   slot_index;
  } in_item_t;

  typedef struct packed {
    logic                found;
    logic [POINT_W-1:0]  out_point;
    logic [KEY_W-1:0]    out_key;
    logic [COUNT_W-1:0]  count_now;
  } out_item_t;

endpackage

FILE: hw/rtl/bmhq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module bmhq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/bounded_min_heap_queue.sv
// Top level of the bounded min-heap queue: sequencer, shared comparator and heap RAM.
//
// A binary min-heap of (distance key, point id) entries held in one RAM of
// CAPACITY+1 entries, with one transaction in and exactly one transaction out
// per operation. The block takes one operation at a time: in_ready is high only
// while the sequencer is idle, and a new operation may be taken while the
// previous result still waits on the output register. A clear, a pop of an
// empty heap and a look beyond the count go straight to the finish state, and a
// look that hits first reads its slot. A push compares the new entry with each
// parent in turn and then writes it. A pop reads the root; unless that was the
// last entry, it then reads the last entry and sinks it, reading the left child,
// then the right child where there is one, and moving the smaller child up while
// it is smaller than the sinking entry. The sequencer holds a finished result
// for as long as the output register is still full. The walk is paced by the
// single read port of the heap RAM, whose registered read gives one entry per
// cycle, and by the one key comparator that every step of the walk shares. The
// size limit is written through cfg_we and cfg_wdata; the user must write it only
// while the block is idle, as the block itself does not enforce this. A limit
// above CAPACITY acts as CAPACITY. Once the heap holds the limit, a push still
// rises through the heap, but the entry left in the spare slot at the count is
// dropped. Slots that were never written are never read, so the RAM needs no
// clearing after reset.
module bounded_min_heap_queue import bmhq_pkg::*; #(
  parameter int CAPACITY = 256,
  parameter int ID_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_data,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata
);

  // Heap geometry: the RAM holds one spare slot beyond the capacity.
  localparam int DEPTH = CAPACITY + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int LW    = (AW > LIMIT_W) ? AW : LIMIT_W;
  localparam int EW    = KEY_W + ID_BITS;

  localparam logic [LW-1:0] CAP_L = LW'(CAPACITY);

  // One-hot sequencer states.
  typedef enum logic [10:0] {
    S_IDLE     = 11'b00000000001,
    S_DISPATCH = 11'b00000000010,
    S_RISE     = 11'b00000000100,
    S_POP_ROOT = 11'b00000001000,
    S_POP_LAST = 11'b00000010000,
    S_SINK_LD  = 11'b00000100000,
    S_SINK_RD  = 11'b00001000000,
    S_SINK_DEC = 11'b00010000000,
    S_LOOK_RD  = 11'b00100000000,
    S_WRITE_E  = 11'b01000000000,
    S_FINISH   = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  // Control registers.
  logic [LIMIT_W-1:0] limit_r;
  logic [AW-1:0]      count_r, count_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Working registers of the operation in flight.
  in_item_t           item_r, item_nxt;
  logic [KEY_W-1:0]   e_key_r, e_key_nxt;
  logic [ID_BITS-1:0] e_id_r, e_id_nxt;
  logic [AW-1:0]      pos_r, pos_nxt;
  logic [KEY_W-1:0]   best_key_r, best_key_nxt;
  logic [ID_BITS-1:0] best_id_r, best_id_nxt;
  logic [AW-1:0]      best_idx_r, best_idx_nxt;
  logic               best_moved_r, best_moved_nxt;
  logic               res_found_r, res_found_nxt;
  logic [KEY_W-1:0]   res_key_r, res_key_nxt;
  logic [POINT_W-1:0] res_point_r, res_point_nxt;
  out_item_t          out_data_r, out_data_nxt;

  // Heap RAM ports.
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [EW-1:0]      ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [EW-1:0]      ram_rdata;
  logic [KEY_W-1:0]   rd_key;
  logic [ID_BITS-1:0] rd_id;

  bmhq_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_heap_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_key = ram_rdata[EW-1:ID_BITS];
  assign rd_id  = ram_rdata[ID_BITS-1:0];

  // The one shared key comparator: its operands are chosen by the state.
  logic [KEY_W-1:0] cmp_a, cmp_b;
  logic             cmp_lt;

  always_comb begin
    cmp_a = rd_key;
    cmp_b = e_key_r;
    if (state_r == S_RISE) begin
      cmp_a = e_key_r;
      cmp_b = rd_key;
    end else if (state_r == S_SINK_RD) begin
      cmp_b = best_key_r;
    end
  end

  assign cmp_lt = cmp_a < cmp_b;

  // Index arithmetic for the heap walk; the child indices are one bit wider than
  // the slot index so that child indices past the capacity still compare correctly.
  logic [AW:0]   left_idx, right_idx, next_left_idx, count_w;
  logic [AW-1:0] up_idx, up_up_idx;
  logic [LW-1:0] active_limit, count_l, slot_l;

  assign count_w       = {1'b0, count_r};
  assign left_idx      = {pos_r, 1'b1};
  assign right_idx     = {pos_r, 1'b0} + (AW+1)'(2);
  assign next_left_idx = {best_idx_r, 1'b1};
  assign up_idx        = (pos_r - AW'(1)) >> 1;
  assign up_up_idx     = (up_idx - AW'(1)) >> 1;

  assign count_l      = LW'(count_r);
  assign slot_l       = LW'(item_r.slot_index);
  assign active_limit = (LW'(limit_r) > CAP_L) ? CAP_L : LW'(limit_r);

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    item_nxt       = item_r;
    e_key_nxt      = e_key_r;
    e_id_nxt       = e_id_r;
    pos_nxt        = pos_r;
    best_key_nxt   = best_key_r;
    best_id_nxt    = best_id_r;
    best_idx_nxt   = best_idx_r;
    best_moved_nxt = best_moved_r;
    res_found_nxt  = res_found_r;
    res_key_nxt    = res_key_r;
    res_point_nxt  = res_point_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r;
    ram_we         = 1'b0;
    ram_waddr      = pos_r;
    ram_wdata      = {e_key_r, e_id_r};
    ram_raddr      = '0;

    // The consumer takes the pending result.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          e_key_nxt = in_data.dist_key;
          e_id_nxt  = ID_BITS'(in_data.point_id);
          pos_nxt   = count_r;
          state_nxt = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        res_found_nxt = 1'b0;
        res_key_nxt   = '0;
        res_point_nxt = '0;
        unique case (item_r.func)
          FUNC_PUSH: begin
            if (count_l < active_limit) begin
              count_nxt = count_r + AW'(1);
            end
            if (pos_r == '0) begin
              state_nxt = S_WRITE_E;
            end else begin
              ram_raddr = up_idx;
              state_nxt = S_RISE;
            end
          end
          FUNC_POP: begin
            if (count_r == '0) begin
              state_nxt = S_FINISH;
            end else begin
              ram_raddr = '0;
              state_nxt = S_POP_ROOT;
            end
          end
          FUNC_CLEAR: begin
            count_nxt = '0;
            state_nxt = S_FINISH;
          end
          default: begin
            if (slot_l < count_l) begin
              ram_raddr = AW'(item_r.slot_index);
              state_nxt = S_LOOK_RD;
            end else begin
              state_nxt = S_FINISH;
            end
          end
        endcase
      end

      S_RISE: begin
        // The parent moves down while the new entry is strictly smaller.
        if (cmp_lt) begin
          ram_we    = 1'b1;
          ram_waddr = pos_r;
          ram_wdata = ram_rdata;
          pos_nxt   = up_idx;
          if (up_idx == '0) begin
            state_nxt = S_WRITE_E;
          end else begin
            ram_raddr = up_up_idx;
          end
        end else begin
          state_nxt = S_WRITE_E;
        end
      end

      S_POP_ROOT: begin
        res_found_nxt = 1'b1;
        res_key_nxt   = rd_key;
        res_point_nxt = POINT_W'(rd_id);
        count_nxt     = count_r - AW'(1);
        if (count_r == AW'(1)) begin
          state_nxt = S_FINISH;
        end else begin
          ram_raddr = count_r - AW'(1);
          state_nxt = S_POP_LAST;
        end
      end

      S_POP_LAST: begin
        // The last entry becomes the one that sinks from the root.
        e_key_nxt = rd_key;
        e_id_nxt  = rd_id;
        pos_nxt   = '0;
        if ((AW+1)'(1) < count_w) begin
          ram_raddr = AW'(1);
          state_nxt = S_SINK_LD;
        end else begin
          state_nxt = S_WRITE_E;
        end
      end

      S_SINK_LD: begin
        if (cmp_lt) begin
          best_key_nxt   = rd_key;
          best_id_nxt    = rd_id;
          best_idx_nxt   = left_idx[AW-1:0];
          best_moved_nxt = 1'b1;
        end else begin
          best_key_nxt   = e_key_r;
          best_id_nxt    = e_id_r;
          best_idx_nxt   = pos_r;
          best_moved_nxt = 1'b0;
        end
        if (right_idx < count_w) begin
          ram_raddr = right_idx[AW-1:0];
          state_nxt = S_SINK_RD;
        end else begin
          state_nxt = S_SINK_DEC;
        end
      end

      S_SINK_RD: begin
        // On equal children the left one stays the choice.
        if (cmp_lt) begin
          best_key_nxt   = rd_key;
          best_id_nxt    = rd_id;
          best_idx_nxt   = right_idx[AW-1:0];
          best_moved_nxt = 1'b1;
        end
        state_nxt = S_SINK_DEC;
      end

      S_SINK_DEC: begin
        if (best_moved_r) begin
          ram_we    = 1'b1;
          ram_waddr = pos_r;
          ram_wdata = {best_key_r, best_id_r};
          pos_nxt   = best_idx_r;
          if (next_left_idx < count_w) begin
            ram_raddr = next_left_idx[AW-1:0];
            state_nxt = S_SINK_LD;
          end else begin
            state_nxt = S_WRITE_E;
          end
        end else begin
          state_nxt = S_WRITE_E;
        end
      end

      S_LOOK_RD: begin
        res_found_nxt = 1'b1;
        res_key_nxt   = rd_key;
        res_point_nxt = POINT_W'(rd_id);
        state_nxt     = S_FINISH;
      end

      S_WRITE_E: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r;
        ram_wdata = {e_key_r, e_id_r};
        state_nxt = S_FINISH;
      end

      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt.found     = res_found_r;
          out_data_nxt.out_point = res_point_r;
          out_data_nxt.out_key   = res_key_r;
          out_data_nxt.count_now = count_l[COUNT_W-1:0];
          out_valid_nxt          = 1'b1;
          state_nxt              = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      limit_r     <= LIMIT_RESET;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    item_r       <= item_nxt;
    e_key_r      <= e_key_nxt;
    e_id_r       <= e_id_nxt;
    pos_r        <= pos_nxt;
    best_key_r   <= best_key_nxt;
    best_id_r    <= best_id_nxt;
    best_idx_r   <= best_idx_nxt;
    best_moved_r <= best_moved_nxt;
    res_found_r  <= res_found_nxt;
    res_key_r    <= res_key_nxt;
    res_point_r  <= res_point_nxt;
    out_data_r   <= out_data_nxt;
  end

`ifndef SYNTHESIS
  // An accepted transaction makes the sequencer busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready stayed high after an accepted transaction");

  // Only pop and look may return an entry.
  a_found_only_pop_look: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && res_found_r) |->
      (item_r.func == FUNC_POP || item_r.func == FUNC_LOOK))
    else $error("entry returned by an operation that returns none");

  // Heap writes stay inside the RAM, spare slot included.
  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (LW'(ram_waddr) <= CAP_L))
    else $error("heap write beyond the last slot");

  // A sinking entry only ever moves further down the heap.
  a_sink_moves_down: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SINK_DEC && best_moved_r) |-> (best_idx_r > pos_r))
    else $error("sink step chose a slot that is not a child");
`endif

endmodule
